// File: design/csed_pkg.sv
// Package: shared types, decode modes and character helpers for the escape decoder.
`timescale 1ns / 1ps

package csed_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned ModeW = 3;

  localparam logic [CharW-1:0] ChBackslash = 8'h5C;
  localparam logic [CharW-1:0] ChLowerX    = 8'h78;

  typedef struct packed {
    logic [CharW-1:0] in_char;
    logic             in_last;
  } csed_in_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             error;
    logic             out_last;
  } csed_out_t;

  typedef enum logic [ModeW-1:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_HEX1  = 3'd2,
    MODE_HEX2  = 3'd3,
    MODE_OCT2  = 3'd4,
    MODE_OCT3  = 3'd5,
    MODE_DROP  = 3'd6
  } csed_mode_t;

  // {ok, value}
  function automatic logic [4:0] hex_digit(input logic [CharW-1:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // {ok, value}
  function automatic logic [3:0] oct_digit(input logic [CharW-1:0] c);
    logic [3:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h37) begin
      r = {1'b1, 3'(c - 8'h30)};
    end
    return r;
  endfunction

  // {ok, code} for single-letter escapes and quoted punctuation
  function automatic logic [CharW:0] simple_escape(input logic [CharW-1:0] c);
    logic [CharW:0] r;
    r = '0;
    case (c)
      8'h6E: r = {1'b1, 8'd10};  // n
      8'h72: r = {1'b1, 8'd13};  // r
      8'h27: r = {1'b1, 8'd39};  // single quote
      8'h22: r = {1'b1, 8'd34};  // double quote
      8'h3F: r = {1'b1, 8'd63};  // ?
      8'h61: r = {1'b1, 8'd7};   // a
      8'h62: r = {1'b1, 8'd8};   // b
      8'h66: r = {1'b1, 8'd12};  // f
      8'h74: r = {1'b1, 8'd9};   // t
      8'h76: r = {1'b1, 8'd11};  // v
      8'h5C: r = {1'b1, 8'd92};  // backslash
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: design/c_escape_sequence_decoder.sv
// Top level: C string literal escape decoder with input and result registers.
// Throughput: one word per cycle unless a word with a result meets a stalled result
// register; the decode is one pass of shallow logic between the input register and the
// result register, and the result register frees in the same cycle it is taken.
// Reset: synchronous rst_n clears both valid flags, plain mode and the accumulator.
`timescale 1ns / 1ps

module c_escape_sequence_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  csed_pkg::csed_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output csed_pkg::csed_out_t out_data
);

  logic                       in_v_r;
  csed_pkg::csed_in_t         in_r;
  csed_pkg::csed_mode_t       mode_r;
  csed_pkg::csed_mode_t       mode_nxt;
  logic [csed_pkg::CharW-1:0] acc_r;
  logic [csed_pkg::CharW-1:0] acc_nxt;
  logic                       res_valid;
  csed_pkg::csed_out_t        res;
  logic                       out_v_r;
  csed_pkg::csed_out_t        out_r;
  logic                       out_free;
  logic                       dec_take;

  csed_decode u_decode (
    .mode      (mode_r),
    .acc       (acc_r),
    .word      (in_r),
    .mode_nxt  (mode_nxt),
    .acc_nxt   (acc_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free = !out_v_r || out_ready;
  // a word with no result never waits on the output side
  assign dec_take = in_v_r && (!res_valid || out_free);
  assign in_ready = !in_v_r || dec_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      mode_r  <= csed_pkg::MODE_PLAIN;
      acc_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) in_v_r <= in_valid;
      if (dec_take) begin
        mode_r <= mode_nxt;
        acc_r  <= acc_nxt;
      end
      if (dec_take && res_valid) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_r <= in_data;
    if (dec_take && res_valid) out_r <= res;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// File: design/csed_decode.sv
// Combinational per-character escape decode: next mode, accumulator and result.
`timescale 1ns / 1ps

module csed_decode (
  input  csed_pkg::csed_mode_t          mode,
  input  logic [csed_pkg::CharW-1:0]    acc,
  input  csed_pkg::csed_in_t            word,
  output csed_pkg::csed_mode_t          mode_nxt,
  output logic [csed_pkg::CharW-1:0]    acc_nxt,
  output logic                          res_valid,
  output csed_pkg::csed_out_t           res
);

  logic [csed_pkg::CharW:0]   simp;
  logic [4:0]                 hx;
  logic [3:0]                 oc;
  logic [csed_pkg::CharW-1:0] c;
  logic                       last;

  assign c    = word.in_char;
  assign last = word.in_last;
  assign simp = csed_pkg::simple_escape(c);
  assign hx   = csed_pkg::hex_digit(c);
  assign oc   = csed_pkg::oct_digit(c);

  always_comb begin
    logic                       do_char;
    logic                       do_err;
    logic [csed_pkg::CharW-1:0] ch;
    do_char   = 1'b0;
    do_err    = 1'b0;
    ch        = '0;
    mode_nxt  = mode;
    acc_nxt   = acc;
    unique case (mode)
      csed_pkg::MODE_DROP: begin
        if (last) mode_nxt = csed_pkg::MODE_PLAIN;
      end
      csed_pkg::MODE_ESC: begin
        if (simp[csed_pkg::CharW]) begin
          do_char = 1'b1;
          ch      = simp[csed_pkg::CharW-1:0];
        end else if (c == csed_pkg::ChLowerX) begin
          if (last) begin
            do_err = 1'b1;
          end else begin
            acc_nxt  = '0;
            mode_nxt = csed_pkg::MODE_HEX1;
          end
        end else if (oc[3]) begin
          if (last) begin
            do_err = 1'b1;
          end else begin
            acc_nxt  = {5'd0, oc[2:0]};
            mode_nxt = csed_pkg::MODE_OCT2;
          end
        end else begin
          do_err = 1'b1;
        end
      end
      csed_pkg::MODE_HEX1: begin
        if (!hx[4] || last) begin
          do_err = 1'b1;
        end else begin
          acc_nxt  = {4'd0, hx[3:0]};
          mode_nxt = csed_pkg::MODE_HEX2;
        end
      end
      csed_pkg::MODE_HEX2: begin
        if (!hx[4]) begin
          do_err = 1'b1;
        end else begin
          do_char = 1'b1;
          ch      = {acc[3:0], hx[3:0]};
        end
      end
      csed_pkg::MODE_OCT2: begin
        if (!oc[3] || last) begin
          do_err = 1'b1;
        end else begin
          acc_nxt  = {acc[4:0], oc[2:0]};
          mode_nxt = csed_pkg::MODE_OCT3;
        end
      end
      csed_pkg::MODE_OCT3: begin
        if (!oc[3]) begin
          do_err = 1'b1;
        end else begin
          do_char = 1'b1;
          ch      = {acc[4:0], oc[2:0]};
        end
      end
      default: begin
        // plain mode, and the unused code behaves the same
        if (c == csed_pkg::ChBackslash) begin
          if (last) begin
            do_err = 1'b1;
          end else begin
            acc_nxt  = '0;
            mode_nxt = csed_pkg::MODE_ESC;
          end
        end else begin
          do_char = 1'b1;
          ch      = c;
        end
      end
    endcase

    if (do_char) begin
      mode_nxt = csed_pkg::MODE_PLAIN;
      acc_nxt  = '0;
    end
    if (do_err) begin
      mode_nxt = last ? csed_pkg::MODE_PLAIN : csed_pkg::MODE_DROP;
      acc_nxt  = '0;
    end

    res_valid    = do_char | do_err;
    res.out_char = do_err ? '0 : ch;
    res.error    = do_err;
    res.out_last = do_err | last;
  end

endmodule

// File: design/csed_checker.sv
// Port-level checker for the escape decoder, bound to the top level.
`timescale 1ns / 1ps

module csed_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input csed_pkg::csed_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed or dropped while stalled");

  a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.out_last)
    else $error("error result does not end the literal");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.out_char == '0)
    else $error("error result carries a nonzero character");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && $past(!in_valid) && $past(rst_n) && $past(in_ready) && $past(!out_valid)
      && $past(!out_valid, 2) && $past(in_ready, 2) && $past(!in_valid, 2) && $past(rst_n, 2)
      |-> !out_valid)
    else $error("result appeared with no word accepted");

endmodule

bind c_escape_sequence_decoder csed_checker u_csed_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: verif/c_escape_sequence_decoder_test.sv
// Testbench: self-checking regression of the C escape decoder under random idling and stalls.
`timescale 1ns / 1ps

module c_escape_sequence_decoder_test;

  localparam int DrainTail  = 8;
  localparam int StallLimit = 3000;
  localparam int LongHold   = 400;

  localparam logic [7:0] ChBslash = csed_pkg::ChBackslash;
  localparam logic [7:0] ChX      = csed_pkg::ChLowerX;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  csed_pkg::csed_in_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  csed_pkg::csed_out_t out_data;

  c_escape_sequence_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // decoder state mirror
  csed_pkg::csed_mode_t dec_mode = csed_pkg::MODE_PLAIN;
  logic [7:0]           dec_acc  = '0;
  csed_pkg::csed_out_t  decoded_q[$];
  logic [7:0]           lit_q[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_len      = 0;
  int hold_serial   = 0;

  int chars_sent      = 0;
  int literals_sent   = 0;
  int results_checked = 0;
  int error_results   = 0;
  int mismatches      = 0;
  int quiet_cycles    = 0;

  function automatic void lit_add(input logic [7:0] c);
    lit_q.insert(lit_q.size(), c);
  endfunction

  function automatic int hex_digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic int oct_digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "7") return int'(c) - int'("0");
    return -1;
  endfunction

  task automatic predict_decode(input csed_pkg::csed_in_t w);
    int                  code;
    int                  hx;
    int                  ov;
    bit                  emit;
    bit                  fail;
    logic [7:0]          val;
    csed_pkg::csed_out_t r;
    code = -1;
    hx   = hex_digit_value(w.in_char);
    ov   = oct_digit_value(w.in_char);
    emit = 1'b0;
    fail = 1'b0;
    val  = '0;
    case (w.in_char)
      "n":  code = 10;
      "r":  code = 13;
      "'":  code = 39;
      "\"": code = 34;
      "?":  code = 63;
      "a":  code = 7;
      "b":  code = 8;
      "f":  code = 12;
      "t":  code = 9;
      "v":  code = 11;
      "\\": code = 92;
      default: code = -1;
    endcase
    case (dec_mode)
      csed_pkg::MODE_DROP: begin
        if (w.in_last) dec_mode = csed_pkg::MODE_PLAIN;
      end
      csed_pkg::MODE_ESC: begin
        if (code >= 0) begin
          emit = 1'b1;
          val  = code[7:0];
        end else if (w.in_char == ChX) begin
          if (w.in_last) begin
            fail = 1'b1;
          end else begin
            dec_acc  = '0;
            dec_mode = csed_pkg::MODE_HEX1;
          end
        end else if (ov >= 0) begin
          if (w.in_last) begin
            fail = 1'b1;
          end else begin
            dec_acc  = ov[7:0];
            dec_mode = csed_pkg::MODE_OCT2;
          end
        end else begin
          fail = 1'b1;
        end
      end
      csed_pkg::MODE_HEX1: begin
        if (hx < 0 || w.in_last) begin
          fail = 1'b1;
        end else begin
          dec_acc  = hx[7:0];
          dec_mode = csed_pkg::MODE_HEX2;
        end
      end
      csed_pkg::MODE_HEX2: begin
        if (hx < 0) begin
          fail = 1'b1;
        end else begin
          emit = 1'b1;
          val  = {dec_acc[3:0], hx[3:0]};
        end
      end
      csed_pkg::MODE_OCT2: begin
        if (ov < 0 || w.in_last) begin
          fail = 1'b1;
        end else begin
          dec_acc  = {dec_acc[4:0], ov[2:0]};
          dec_mode = csed_pkg::MODE_OCT3;
        end
      end
      csed_pkg::MODE_OCT3: begin
        if (ov < 0) begin
          fail = 1'b1;
        end else begin
          emit = 1'b1;
          val  = {dec_acc[4:0], ov[2:0]};
        end
      end
      default: begin
        // plain mode, and the spare encoding acts the same
        if (w.in_char == ChBslash) begin
          if (w.in_last) begin
            fail = 1'b1;
          end else begin
            dec_mode = csed_pkg::MODE_ESC;
            dec_acc  = '0;
          end
        end else begin
          emit = 1'b1;
          val  = w.in_char;
        end
      end
    endcase
    if (emit) begin
      r.out_char = val;
      r.error    = 1'b0;
      r.out_last = w.in_last;
      decoded_q.insert(decoded_q.size(), r);
      dec_mode = csed_pkg::MODE_PLAIN;
      dec_acc  = '0;
    end else if (fail) begin
      r.out_char = '0;
      r.error    = 1'b1;
      r.out_last = 1'b1;
      decoded_q.insert(decoded_q.size(), r);
      dec_mode = w.in_last ? csed_pkg::MODE_PLAIN : csed_pkg::MODE_DROP;
      dec_acc  = '0;
    end
  endtask

  // Valid is only dropped when idling, so back-to-back words never see a low/high pair.
  task automatic send_word(input logic [7:0] c, input bit last);
    csed_pkg::csed_in_t w;
    w.in_char = c;
    w.in_last = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    if (last) literals_sent++;
    predict_decode(w);
  endtask

  task automatic send_literal();
    for (int i = 0; i < lit_q.size(); i++) begin
      send_word(lit_q[i], i == lit_q.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    lit_q.delete();
    for (int i = 0; i < s.len(); i++) lit_add(s[i]);
    send_literal();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DrainTail) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct    <= recv_pct;
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'(int'("0") + v);
    return 8'(($urandom_range(1) ? int'("a") : int'("A")) + v - 10);
  endfunction

  function automatic logic [7:0] rand_oct_char();
    return 8'(int'("0") + $urandom_range(7));
  endfunction

  task automatic build_literal();
    int pieces;
    int pick;
    int keep;
    lit_q.delete();
    pieces = $urandom_range(1, 8);
    repeat (pieces) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        lit_add(8'($urandom_range(255)));
      end else if (pick < 65) begin
        lit_add(ChBslash);
        case ($urandom_range(10))
          0: lit_add("n");
          1: lit_add("r");
          2: lit_add("'");
          3: lit_add("\"");
          4: lit_add("?");
          5: lit_add("a");
          6: lit_add("b");
          7: lit_add("f");
          8: lit_add("t");
          9: lit_add("v");
          default: lit_add("\\");
        endcase
      end else if (pick < 78) begin
        lit_add(ChBslash);
        lit_add(ChX);
        lit_add(rand_hex_char());
        lit_add(rand_hex_char());
      end else if (pick < 90) begin
        lit_add(ChBslash);
        repeat (3) lit_add(rand_oct_char());
      end else begin
        // malformed escape: arbitrary bytes where digits or a letter belong
        lit_add(ChBslash);
        case ($urandom_range(2))
          0: lit_add(8'($urandom_range(255)));
          1: begin
            lit_add(ChX);
            lit_add(8'($urandom_range(255)));
            lit_add(8'($urandom_range(255)));
          end
          default: begin
            lit_add(rand_oct_char());
            lit_add(8'($urandom_range(255)));
            lit_add(8'($urandom_range(255)));
          end
        endcase
      end
    end
    // cut short so the last flag can land inside an escape
    if ($urandom_range(99) < 12) begin
      keep = $urandom_range(1, lit_q.size());
      while (lit_q.size() > keep) lit_q.delete(lit_q.size() - 1);
    end
  endtask

  task automatic run_literals(input int n_words);
    int target;
    target = chars_sent + n_words;
    while (chars_sent < target) begin
      if ($urandom_range(99) < 6) begin
        repeat ($urandom_range(1, 6)) begin
          send_word(8'($urandom_range(255)), $urandom_range(3) == 0);
        end
      end else begin
        build_literal();
        send_literal();
      end
    end
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_text("\\n\\x4F\\777\\\\");
    send_text("\\qzy");
    send_text("\\xG");
    send_text("\\1");
    send_text("\\18");
    send_text("\\");
    wait_drained();
  endtask

  task automatic test_steady_stream();
    set_idling(0, 0);
    run_literals(450);
    wait_drained();
  endtask

  task automatic test_sender_gaps();
    set_idling(75, 0);
    run_literals(350);
    wait_drained();
  endtask

  task automatic test_receiver_stalls();
    set_idling(0, 75);
    run_literals(350);
    wait_drained();
  endtask

  task automatic test_mixed_idling();
    set_idling(32, 32);
    run_literals(450);
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    hold_len    <= LongHold;
    hold_serial <= hold_serial + 1;
    run_literals(80);
    // sender stops here until the backlog has fully drained
    wait_drained();
    run_literals(70);
    wait_drained();
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int seen;
    int left;
    seen = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_serial != seen) begin
        seen = hold_serial;
        left = hold_len;
      end
      if (left > 0) begin
        left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    csed_pkg::csed_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t ns unexpected word: expected none, got %02h/%0b/%0b", $time,
                 out_data.out_char, out_data.error, out_data.out_last);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        results_checked++;
        if (want.error) error_results++;
        if (out_data.out_char !== want.out_char) begin
          $display("%0t ns out_char mismatch: expected %02h, got %02h", $time,
                   want.out_char, out_data.out_char);
          mismatches++;
        end
        if (out_data.error !== want.error) begin
          $display("%0t ns error mismatch: expected %0b, got %0b", $time,
                   want.error, out_data.error);
          mismatches++;
        end
        if (out_data.out_last !== want.out_last) begin
          $display("%0t ns out_last mismatch: expected %0b, got %0b", $time,
                   want.out_last, out_data.out_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t ns timeout: no word moved for %0d cycles, %0d results pending", $time,
               quiet_cycles, decoded_q.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_steady_stream();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    test_backpressure();
    if (decoded_q.size() != 0) begin
      $display("%0t ns %0d expected results never arrived", $time, decoded_q.size());
      mismatches++;
    end
    $display("Sent %0d characters (%0d last flags) with plain, escape, hex, octal and bad input;",
             chars_sent, literals_sent);
    $display("checked %0d results, %0d of them errors, %0d mismatches.",
             results_checked, error_results, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
